### rtl/io_sample_frame_decoder_top_assert.svh
// Assertion macros shared by the decoder modules.
// The enclosing module must have clk and arst_n in scope.
`ifndef IO_SAMPLE_FRAME_DECODER_TOP_ASSERT_SVH
`define IO_SAMPLE_FRAME_DECODER_TOP_ASSERT_SVH

`define SFD_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sfd_pkg.sv
package sfd_pkg;

	localparam logic [7:0]  HEADER_BYTE   = 8'h01;
	localparam logic [15:0] DIG_PINS_USED = 16'h1CFF;
	localparam logic [7:0]  ANA_PINS_USED = 8'h8F;
	localparam int          QDEPTH        = 4;
	localparam int          QAW           = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic        pin_is_analog;
		logic [3:0]  pin_number;
		logic [15:0] pin_value;
		logic        last_of_run;
		logic        last_of_sample;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DMASK_HI,
		PH_DMASK_LO,
		PH_AMASK,
		PH_DSAMP_HI,
		PH_DSAMP_LO,
		PH_ASAMP_HI,
		PH_ASAMP_LO
	} phase_t;

	// One unit of work for the back end: a digital run or one analog result.
	typedef struct packed {
		logic        is_analog;
		logic [12:0] mask;
		logic [3:0]  pin;
		logic [15:0] value;
		logic        final_flag;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [3:0] lowest_index(input logic [12:0] m);
		logic [3:0] idx;
		idx = 4'd0;
		for (int i = 12; i >= 0; i--) begin
			if (m[i]) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/io_sample_frame_decoder_top.sv
// IO sample frame decoder.
// Input channel frame_valid / frame_stall / frame_data carries one frame byte per
// transfer; frame_start marks the header byte and restarts the parse.
// Output channel result_valid / result_stall / result_data carries one pin result
// per transfer: digital levels for enabled pins 0-7 and 10-12 on the low byte of
// the digital sample, then one analog result per enabled analog pin 0-3 and 7.
// The parser takes one byte per cycle while the queue has room and queues work
// (a digital run or an analog result) in a 4-entry queue; the emitter sends one
// result per cycle while result_stall is low; results pass through cur_q and out_q.
// Throughput: 1 byte per cycle while the queue has room; a digital sample low
// byte costs one emitter cycle per enabled pin (up to 11), which sets the
// sustained rate for bursts. Other bytes cost at most one emitter cycle.
// When result_stall is high the output register holds its result; once the
// queue fills, frame_stall rises until the emitter frees an entry.
// Reset clears the parse state, the queue and the output valid; the first byte
// taken after reset is honored only if it carries frame_start.
module io_sample_frame_decoder_top import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_stall,
	input  in_item_t  frame_data,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_data
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head;

	sfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_data  (frame_data),
		.q_stat      (q_stat),
		.push        (push),
		.job         (push_job)
	);

	sfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	sfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

### rtl/sfd_front.sv
module sfd_front import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_stall,
	input  in_item_t  frame_data,
	input  q_status_t q_stat,
	output logic      push,
	output job_t      job
);

	phase_t      state_q, state_n;
	logic [15:0] dmask_q, dmask_n;
	logic [7:0]  pend_q, pend_n;
	logic [7:0]  held_q, held_n;
	logic        accept;
	logic [12:0] dig_en;
	logic [7:0]  low_bit;
	logic [7:0]  pend_left;

	assign frame_stall = q_stat.full;
	assign accept      = frame_valid && !q_stat.full;
	assign dig_en      = dmask_q[12:0] & DIG_PINS_USED[12:0];
	assign low_bit     = pend_q & (~pend_q + 8'd1);
	assign pend_left   = pend_q & ~low_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			dmask_q <= '0;
			pend_q  <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_n;
			dmask_q <= dmask_n;
			pend_q  <= pend_n;
			held_q  <= held_n;
		end
	end

	always_comb begin
		state_n = state_q;
		dmask_n = dmask_q;
		pend_n  = pend_q;
		held_n  = held_q;
		push    = 1'b0;
		job     = '0;
		if (accept) begin
			if (frame_data.frame_start) begin
				dmask_n = '0;
				pend_n  = '0;
				held_n  = '0;
				state_n = (frame_data.data_byte == HEADER_BYTE) ? PH_DMASK_HI : PH_IDLE;
			end else begin
				unique case (state_q)
					PH_IDLE: begin
					end
					PH_DMASK_HI: begin
						dmask_n = {frame_data.data_byte, 8'h00};
						state_n = PH_DMASK_LO;
					end
					PH_DMASK_LO: begin
						dmask_n = {dmask_q[15:8], frame_data.data_byte};
						state_n = PH_AMASK;
					end
					PH_AMASK: begin
						pend_n = frame_data.data_byte & ANA_PINS_USED;
						if (dmask_q != 16'h0000) begin
							state_n = PH_DSAMP_HI;
						end else begin
							state_n = (pend_n != 8'h00) ? PH_ASAMP_HI : PH_IDLE;
						end
					end
					PH_DSAMP_HI: begin
						held_n  = frame_data.data_byte;
						state_n = PH_DSAMP_LO;
					end
					PH_ASAMP_HI: begin
						held_n  = frame_data.data_byte;
						state_n = PH_ASAMP_LO;
					end
					PH_DSAMP_LO: begin
						if (dig_en != 13'h0000) begin
							push           = 1'b1;
							job.is_analog  = 1'b0;
							job.mask       = dig_en;
							job.value      = {held_q, frame_data.data_byte};
							job.final_flag = (pend_q == 8'h00);
						end
						state_n = (pend_q != 8'h00) ? PH_ASAMP_HI : PH_IDLE;
					end
					PH_ASAMP_LO: begin
						if (pend_q != 8'h00) begin
							pend_n         = pend_left;
							push           = 1'b1;
							job.is_analog  = 1'b1;
							job.pin        = lowest_index({5'b0, pend_q});
							job.value      = {held_q, frame_data.data_byte};
							job.final_flag = (pend_left == 8'h00);
						end
						state_n = (pend_n != 8'h00) ? PH_ASAMP_HI : PH_IDLE;
					end
				endcase
			end
		end
	end

endmodule

### rtl/sfd_queue.sv
`include "io_sample_frame_decoder_top_assert.svh"

module sfd_queue import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t stat
);

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (count_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	`SFD_ASSERT(a_count_range, count_q <= (QAW+1)'(QDEPTH), "queue count over depth")
	`SFD_ASSERT(a_no_pop_empty, !(pop && stat.empty), "pop from empty queue")
	`SFD_ASSERT(a_no_push_full, !(push && stat.full), "push into full queue")
	`SFD_ASSERT_NEXT(a_fill_step, push && !pop, count_q == $past(count_q) + 1'b1, "count did not rise")

endmodule

### rtl/sfd_back.sv
module sfd_back import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  q_status_t q_stat,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_data
);

	job_t        cur_q;
	logic        cur_valid_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        can_emit;
	logic        done;
	logic        load;
	logic [12:0] low_bit;
	logic [12:0] rest;
	logic [3:0]  dpin;
	out_item_t   res;

	assign low_bit  = cur_q.mask & (~cur_q.mask + 13'd1);
	assign rest     = cur_q.mask & ~low_bit;
	assign dpin     = lowest_index(cur_q.mask);
	assign can_emit = cur_valid_q && (!out_valid_q || !result_stall);
	assign done     = cur_q.is_analog || (rest == 13'h0000);
	assign load     = !cur_valid_q || (can_emit && done);
	assign pop      = load && !q_stat.empty;

	always_comb begin
		res.pin_is_analog = cur_q.is_analog;
		if (cur_q.is_analog) begin
			res.pin_number     = cur_q.pin;
			res.pin_value      = cur_q.value;
			res.last_of_run    = 1'b1;
			res.last_of_sample = cur_q.final_flag;
		end else begin
			res.pin_number     = dpin;
			res.pin_value      = {15'b0, cur_q.value[dpin]};
			res.last_of_run    = (rest == 13'h0000);
			res.last_of_sample = (rest == 13'h0000) && cur_q.final_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= !q_stat.empty;
			end
			if (can_emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head;
		end else if (can_emit) begin
			cur_q.mask <= rest;
		end
		if (can_emit) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import sfd_pkg::*;

	localparam int LIMIT     = 400000;
	localparam int LONG_HOLD = 300;

	typedef struct {
		in_item_t item;
		bit       drain;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      frame_valid = 1'b0;
	logic      frame_stall;
	in_item_t  frame_data = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result_data;

	stim_t     byte_queue[$];
	out_item_t pins_due[$];
	out_item_t want;

	// decoder state mirror
	phase_t      ph;
	logic [15:0] dig_en;
	logic [7:0]  ana_en, ana_pend, held_hi;

	int n_due = 0, n_seen = 0, n_taken = 0, n_frame_bytes = 0;
	int n_digital = 0, n_analog = 0, errors = 0, cycles = 0;
	int gap_left, calm_left, stall_left, hold_left, stall_pick;
	bit stall_level, hold_done;

	io_sample_frame_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_data(frame_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	initial forever #1 clk = ~clk;

	task automatic decode_byte(input in_item_t it);
		logic [15:0] sample;
		logic [12:0] en;
		out_item_t   r;
		int          p;
		sample = {held_hi, it.data_byte};
		if (it.frame_start) begin
			dig_en = '0;
			ana_en = '0;
			ana_pend = '0;
			held_hi = '0;
			ph = (it.data_byte == HEADER_BYTE) ? PH_DMASK_HI : PH_IDLE;
		end else begin
			case (ph)
				PH_DMASK_HI: begin
					dig_en = {it.data_byte, 8'h00};
					ph = PH_DMASK_LO;
				end
				PH_DMASK_LO: begin
					dig_en[7:0] = it.data_byte;
					ph = PH_AMASK;
				end
				PH_AMASK: begin
					ana_en = it.data_byte;
					ana_pend = it.data_byte & ANA_PINS_USED;
					if (dig_en != 16'd0)
						ph = PH_DSAMP_HI;
					else
						ph = (ana_pend != 8'd0) ? PH_ASAMP_HI : PH_IDLE;
				end
				PH_DSAMP_HI: begin
					held_hi = it.data_byte;
					ph = PH_DSAMP_LO;
				end
				PH_ASAMP_HI: begin
					held_hi = it.data_byte;
					ph = PH_ASAMP_LO;
				end
				PH_DSAMP_LO: begin
					en = 13'(dig_en & DIG_PINS_USED);
					for (p = 0; p < 13; p++) begin
						if (en[p]) begin
							r.pin_is_analog = 1'b0;
							r.pin_number = 4'(p);
							r.pin_value = {15'd0, sample[p]};
							r.last_of_run = ((en >> (p + 1)) == 13'd0);
							r.last_of_sample = r.last_of_run && (ana_pend == 8'd0);
							pins_due.push_back(r);
							n_due++;
						end
					end
					ph = (ana_pend != 8'd0) ? PH_ASAMP_HI : PH_IDLE;
				end
				PH_ASAMP_LO: begin
					p = 0;
					while (p < 8 && !ana_pend[p])
						p++;
					if (p < 8) begin
						ana_pend[p] = 1'b0;
						r.pin_is_analog = 1'b1;
						r.pin_number = 4'(p);
						r.pin_value = sample;
						r.last_of_run = 1'b1;
						r.last_of_sample = (ana_pend == 8'd0);
						pins_due.push_back(r);
						n_due++;
					end
					ph = (ana_pend != 8'd0) ? PH_ASAMP_HI : PH_IDLE;
				end
				default: ;
			endcase
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic string fmt_pin(input out_item_t r);
		return $sformatf("analog=%0d pin=%0d value=%h last_run=%0d last_sample=%0d",
			r.pin_is_analog, r.pin_number, r.pin_value, r.last_of_run, r.last_of_sample);
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic s, input bit drain);
		stim_t st;
		st.item.data_byte = b;
		st.item.frame_start = s;
		st.drain = drain;
		byte_queue.push_back(st);
	endtask

	// cut < 0 sends the whole frame, otherwise only its first cut bytes
	task automatic queue_frame(input logic [15:0] dmask, input logic [7:0] amask,
			input int cut, input bit drain);
		logic [7:0]  fb[$];
		logic [15:0] s;
		fb.push_back(HEADER_BYTE);
		fb.push_back(dmask[15:8]);
		fb.push_back(dmask[7:0]);
		fb.push_back(amask);
		if (dmask != 16'd0) begin
			s = 16'($urandom);
			fb.push_back(s[15:8]);
			fb.push_back(s[7:0]);
		end
		for (int p = 0; p < 8; p++) begin
			if (amask[p] && ANA_PINS_USED[p]) begin
				s = 16'($urandom);
				fb.push_back(s[15:8]);
				fb.push_back(s[7:0]);
			end
		end
		for (int i = 0; i < fb.size() && (cut < 0 || i < cut); i++) begin
			queue_byte(fb[i], i == 0, drain && i == 0);
			n_frame_bytes++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
			frame_data <= '0;
			gap_left = 0;
			calm_left = 0;
			ph = PH_IDLE;
			dig_en = '0;
			ana_en = '0;
			ana_pend = '0;
			held_hi = '0;
		end else begin
			if (frame_valid && !frame_stall) begin
				decode_byte(frame_data);
				n_taken++;
			end
			if (!frame_valid || !frame_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					frame_valid <= 1'b0;
				end else if (byte_queue.size() != 0
						&& (!byte_queue[0].drain || n_seen == n_due)) begin
					frame_valid <= 1'b1;
					frame_data <= byte_queue[0].item;
					void'(byte_queue.pop_front());
					gap_left = pick_gap();
				end else begin
					frame_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off to back up the decoder
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
			stall_level = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (!hold_done && n_seen >= 40) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			result_stall <= 1'b1;
		end else begin
			if (stall_left == 0) begin
				stall_pick = $urandom_range(0, 99);
				stall_level = (stall_pick >= 45);
				if (stall_pick < 45)
					stall_left = $urandom_range(1, 30);
				else if (stall_pick < 92)
					stall_left = $urandom_range(1, 3);
				else
					stall_left = $urandom_range(10, 40);
			end
			stall_left--;
			result_stall <= stall_level;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_seen <= n_seen + 1;
			if (result_data.pin_is_analog)
				n_analog++;
			else
				n_digital++;
			if (pins_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %s", fmt_pin(result_data));
			end else begin
				want = pins_due.pop_front();
				if (result_data.pin_is_analog !== want.pin_is_analog
						|| result_data.pin_number !== want.pin_number
						|| result_data.pin_value !== want.pin_value
						|| result_data.last_of_run !== want.last_of_run
						|| result_data.last_of_sample !== want.last_of_sample) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at cycle %0d", cycles);
						$display("  expected %s", fmt_pin(want));
						$display("  actual   %s", fmt_pin(result_data));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", LIMIT);
			$display("io_sample_frame_decoder_top verification failed");
			$finish;
		end
	end

	initial begin
		logic [8:0]  script[25];
		int          kind;
		int          cut;
		logic [15:0] dmask;
		logic [7:0]  amask;
		bit          first;

		// {data_byte, frame_start}
		script = '{
			{8'hFF, 1'b0},                                 // idle, no start: ignored
			{8'hFE, 1'b1}, {8'h01, 1'b0},                  // bad header, then ignored
			{8'h01, 1'b1}, {8'h03, 1'b0}, {8'h00, 1'b0},   // only unused digital bits
			{8'h70, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},   // analog bits 4-6 only
			{8'h01, 1'b1}, {8'h00, 1'b0}, {8'h00, 1'b0},   // nothing enabled
			{8'h00, 1'b0},
			{8'h01, 1'b1}, {8'hFF, 1'b0},                  // restart mid-frame
			{8'h01, 1'b1}, {8'hFF, 1'b0}, {8'hFF, 1'b0},   // all digital pins
			{8'h81, 1'b0}, {8'h55, 1'b0}, {8'hAA, 1'b0},   // analog 0 and 7
			{8'hFF, 1'b0}, {8'hFF, 1'b0},
			{8'h00, 1'b0}, {8'h00, 1'b0}
		};
		for (int i = 0; i < 25; i++)
			queue_byte(script[i][8:1], script[i][0], 1'b0);

		first = 1'b1;
		while (byte_queue.size() < 350) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				case ($urandom_range(0, 3))
					0: dmask = 16'h0000;
					1: dmask = 16'($urandom);
					2: dmask = 16'hFFFF;
					default: dmask = 16'h0001 << $urandom_range(0, 15);
				endcase
				case ($urandom_range(0, 3))
					0: amask = 8'h00;
					3: amask = 8'hFF;
					default: amask = 8'($urandom_range(0, 255));
				endcase
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1;
				queue_frame(dmask, amask, cut, first || $urandom_range(0, 19) == 0);
				first = 1'b0;
			end else if (kind < 88) begin
				repeat ($urandom_range(1, 4))
					queue_byte(8'($urandom), 1'b0, 1'b0);
			end else begin
				queue_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 255)),
					1'b1, 1'b0);
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom), 1'b0, 1'b0);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (byte_queue.size() != 0 || frame_valid);
		while (n_seen != n_due)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (pins_due.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", pins_due.size());
		end
		$display("run: %0d byte transfers (%0d in frames), %0d pin results (%0d digital, %0d analog)",
			n_taken, n_frame_bytes, n_seen, n_digital, n_analog);
		$display("run: %0d cycles, %0d errors", cycles, errors);
		if (errors == 0)
			$display("io_sample_frame_decoder_top verification clean");
		else
			$display("io_sample_frame_decoder_top verification failed");
		$finish;
	end

endmodule
